// ----- rtl/bdec_pkg.sv -----
// Shared constants for the binary to decimal ASCII converter.
// No dependencies; used by the interfaces and the core.
package bdec_pkg;

  localparam int unsigned VALUE_W    = 32;  // input value width
  localparam int unsigned CHAR_W     = 6;   // ASCII digit code width
  localparam int unsigned DIGIT_W    = 4;   // one decimal digit
  localparam int unsigned NUM_DIGITS = 10;  // digits of the largest value
  localparam int unsigned RADIX      = 10;
  localparam int unsigned POS_W      = 4;   // digit position, 0 .. NUM_DIGITS-1
  localparam int unsigned PROD_W     = 34;  // holds 9 * 10^9

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Powers of ten, indexed by digit position.
  localparam logic [VALUE_W-1:0] POW10 [NUM_DIGITS] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000,
    32'd100000, 32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
  };

endpackage

// ----- rtl/bdec_in_if.sv -----
// Request channel carrying one binary value.
// Depends on bdec_pkg.
interface bdec_in_if import bdec_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/bdec_out_if.sv -----
// Result channel carrying one ASCII digit and its end-of-number flag.
// Depends on bdec_pkg.
interface bdec_out_if import bdec_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ----- rtl/binary_to_decimal_ascii_core.sv -----
// Binary to decimal ASCII converter, top level.
// Depends on bdec_pkg, bdec_in_if and bdec_out_if.

// Each 32-bit unsigned request on in_i comes out on out_o as its decimal
// digits in ASCII ('0'..'9'), most significant first, one digit per result,
// with leading zeros dropped; the units digit is always sent and carries
// last, so zero gives a single '0'. The emitter sends one digit per cycle
// while the output register is free or the sink takes its digit, and takes up
// the next pending value in the same cycle that it sends the units digit. A
// request moves from the input register into the emitter; each digit is
// registered in the output register and waits there for the sink while the
// emitter stalls. The input register takes the next request while the emitter
// works on the current one. No configuration; nothing carries over between values.
module binary_to_decimal_ascii_core import bdec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdec_in_if.sink     in_i,
  bdec_out_if.source  out_o
);

  // ---------------------------------------------------------------------
  // Input register: holds one pending request.
  // ---------------------------------------------------------------------
  logic               in_vld_q, in_vld_d;
  logic [VALUE_W-1:0] in_val_q, in_val_d;

  // ---------------------------------------------------------------------
  // Digit emitter: remainder and position of the next digit.
  // ---------------------------------------------------------------------
  logic               busy_q, busy_d;
  logic [VALUE_W-1:0] rest_q, rest_d;
  logic [POS_W-1:0]   pos_q, pos_d;

  // Output register.
  logic               out_vld_q, out_vld_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  logic               emit;       // emitter produces a digit this cycle
  logic               load;       // pending request moves into the emitter
  logic               in_take;
  logic [POS_W-1:0]   start_pos;  // position of the leading digit
  logic [DIGIT_W-1:0] digit;

  // Multiples d * 10^p, constants folded at elaboration.
  logic [PROD_W-1:0]  mult_tbl [NUM_DIGITS][RADIX];

  for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_pos
    for (genvar d = 0; d < RADIX; d++) begin : g_mul
      assign mult_tbl[p][d] = PROD_W'(POW10[p]) * PROD_W'(d);
    end
  end

  // Leading digit position: the highest power of ten not above the value.
  always_comb begin
    start_pos = '0;
    for (int p = 1; p < NUM_DIGITS; p++) begin
      if (in_val_q >= POW10[p]) begin
        start_pos = POS_W'(p);
      end
    end
  end

  // One digit per step: nine parallel compares against the multiples of
  // the current power, then one subtract.
  always_comb begin
    digit = '0;
    for (int d = 1; d < RADIX; d++) begin
      if (PROD_W'(rest_q) >= mult_tbl[pos_q][d]) begin
        digit = DIGIT_W'(d);
      end
    end
  end

  assign rest_d = rest_q - mult_tbl[pos_q][digit][VALUE_W-1:0];

  // Handshake control. The emitter hands over to the next value in the
  // same cycle that it sends the units digit.
  assign emit     = busy_q && (!out_vld_q || out_o.ready);
  assign load     = in_vld_q && (!busy_q || (emit && pos_q == '0));
  assign in_i.ready = !in_vld_q || load;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    in_val_d = in_val_q;
    if (in_take) begin
      in_vld_d = 1'b1;
      in_val_d = in_i.value;
    end else if (load) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (load) begin
      busy_d = 1'b1;
      pos_d  = start_pos;
    end else if (emit) begin
      if (pos_q == '0) begin
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q - POS_W'(1);
      end
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_char_d = ASCII_ZERO + CHAR_W'(digit);
      out_last_d = (pos_q == '0);
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      busy_q    <= 1'b0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      busy_q    <= busy_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk_i) begin
    in_val_q   <= in_val_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (load) begin
      rest_q <= in_val_q;
    end else if (emit) begin
      rest_q <= rest_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last       = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q < POS_W'(NUM_DIGITS))
    else $error("digit position out of range");

  a_units_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && pos_q == '0 |-> rest_q < VALUE_W'(RADIX))
    else $error("remainder too large at units digit");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && pos_q != '0 |=> busy_q && pos_q == $past(pos_q) - POS_W'(1))
    else $error("emitter skipped a digit position");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_vld_q && (out_last_q == ($past(pos_q) == '0)))
    else $error("last flag does not match the units digit");

  a_no_lost_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q)
    else $error("loaded value not in the emitter");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for binary_to_decimal_ascii_core: values in, ASCII digits out.
// Depends on bdec_pkg, bdec_in_if, bdec_out_if and the core RTL.
module testbench import bdec_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // One expected digit result
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } ascii_digit_t;

  localparam int unsigned TAIL_CYCLES = 20;   // well past the first-digit latency
  localparam int unsigned RAND_PER_PHASE = 30;

  logic clk_i = 1'b0;
  logic rst_ni;

  bdec_in_if  in_ch ();
  bdec_out_if out_ch ();

  binary_to_decimal_ascii_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Values waiting to be sent, and the digits the core still owes us
  logic [VALUE_W-1:0] pending_values_q [$];
  ascii_digit_t       owed_digits_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int unsigned error_count   = 0;

  // Decimal expansion of one value. Digits are peeled off the low end by
  // repeated division, then queued most significant first; this gives
  // leading-zero suppression for free, and zero still yields one '0'.
  task automatic queue_expected_digits(input logic [VALUE_W-1:0] number);
    logic [VALUE_W-1:0] rest;
    logic [DIGIT_W-1:0] digits [NUM_DIGITS];
    int                 count;
    ascii_digit_t       entry;
    rest  = number;
    count = 0;
    do begin
      digits[count] = DIGIT_W'(rest % RADIX);
      rest          = rest / RADIX;
      count++;
    end while (rest != 0);
    for (int i = count - 1; i >= 0; i--) begin
      entry.digit_char = ASCII_ZERO + CHAR_W'(digits[i]);
      entry.last       = (i == 0);
      owed_digits_q.push_back(entry);
    end
  endtask

  // Random values spread over every digit count. A quarter are raw 32-bit
  // words (bit coverage), a quarter sit in a random decade, a quarter have
  // scattered zero digits (inner zeros), the rest are tiny.
  function automatic logic [VALUE_W-1:0] random_value();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned acc;
    longint unsigned scale;
    int unsigned     ndig;
    int unsigned     d;
    acc = 0;
    case ($urandom_range(3))
      0: return $urandom;
      1: begin
        ndig = $urandom_range(NUM_DIGITS, 1);
        lo   = 1;
        for (int i = 1; i < ndig; i++) lo = lo * RADIX;
        hi = lo * RADIX - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        return VALUE_W'($urandom_range(int'(hi), int'(lo)));
      end
      2: begin
        scale = 1;
        for (int k = 0; k < NUM_DIGITS; k++) begin
          // top digit kept at 3 or below so the sum stays within 32 bits
          if ($urandom_range(1)) d = 0;
          else d = (k == NUM_DIGITS - 1) ? $urandom_range(3, 1) : $urandom_range(9, 1);
          acc   = acc + d * scale;
          scale = scale * RADIX;
        end
        return VALUE_W'(acc);
      end
      default: return VALUE_W'($urandom_range(99));
    endcase
  endfunction

  // Request driver. A value stays on the bus until taken; a new one is put
  // up only when the bus is free, and the sender idles at send_idle_pct.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) queue_expected_digits(in_ch.value);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_values_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= pending_values_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every taken digit is checked against the oldest one owed.
  // ready is rerolled each cycle so stalls land anywhere in a number.
  always @(posedge clk_i or negedge rst_ni) begin
    ascii_digit_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_digits_q.size() == 0) begin
          $error("unexpected digit result: digit_char %0d last %0b",
                 out_ch.digit_char, out_ch.last);
          error_count++;
        end else begin
          want = owed_digits_q.pop_front();
          if (out_ch.digit_char !== want.digit_char) begin
            $error("digit_char: expected %0d, got %0d", want.digit_char, out_ch.digit_char);
            error_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            error_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Wait until every queued value has been taken by the core
  task automatic wait_all_sent();
    while (pending_values_q.size() != 0 || in_ch.valid) @(negedge clk_i);
  endtask

  task automatic wait_all_digits();
    while (owed_digits_q.size() != 0) @(negedge clk_i);
  endtask

  // Stimulus sequence
  initial begin
    int unsigned send_pct [3];
    int unsigned take_pct [3];
    logic [VALUE_W-1:0] directed [];
    send_pct = '{34, 46, 0};
    take_pct = '{46, 34, 0};
    // Bus signals are cleared by the driver and monitor while reset is low
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero, single digits, decade edges, inner zeros, the largest
    // value (ten digits) and alternating bit patterns.
    directed = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd100000,
      32'd1000010, 32'd10203040, 32'd999999999, 32'd1000000000, 32'd1000000001,
      32'd2147483647, 32'd2147483648, 32'd4000000000, 32'd4294967290,
      32'd4294967294, 32'd4294967295, 32'hAAAA_AAAA, 32'h5555_5555, 32'd7
    };
    send_idle_pct = send_pct[0];
    take_idle_pct = take_pct[0];
    foreach (directed[i]) pending_values_q.push_back(directed[i]);
    wait_all_sent();

    // Hold the sender off until the core has fully drained
    wait_all_digits();

    // Random phases: receiver idles more, then sender idles more, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_pct[phase];
      take_idle_pct = take_pct[phase];
      for (int n = 0; n < RAND_PER_PHASE; n++) pending_values_q.push_back(random_value());
      wait_all_sent();
    end

    wait_all_digits();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (error_count == 0 && owed_digits_q.size() == 0) begin
      $display("binary_to_decimal_ascii_core test passed");
    end else begin
      $display("binary_to_decimal_ascii_core test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #500us;
    $display("binary_to_decimal_ascii_core test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bdec_pkg.sv
rtl/bdec_in_if.sv
rtl/bdec_out_if.sv
rtl/binary_to_decimal_ascii_core.sv
tb/sv/testbench.sv
